// ===== hw/rtl/m3h_pkg.sv =====
// ----------------------------------------------------------------------------
// m3h_pkg
// Shared types and constants of the MurmurHash3 x86 32-bit hash block.
// ----------------------------------------------------------------------------
package m3h_pkg;

    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

    localparam logic [2:0] FULL_BYTES = 3'd4;

    typedef logic [1:0] beat_kind_t;
    localparam beat_kind_t KIND_NONE  = 2'd0;
    localparam beat_kind_t KIND_TAIL  = 2'd1;
    localparam beat_kind_t KIND_BLOCK = 2'd2;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        beat_kind_t  kind;
        logic        last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic [5:0] count;
    } q_status_t;

    typedef struct packed {
        logic mid;
        logic finishing;
        logic pop;
    } back_status_t;

endpackage

// ===== hw/rtl/m3h_front.sv =====
// ----------------------------------------------------------------------------
// m3h_front
// Accepts input beats, saturates the byte count, masks unused tail bytes and
// tags each beat as a full block, a tail or an empty final beat.
// ----------------------------------------------------------------------------
module m3h_front
    import m3h_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word [31:0], byte_count [34:32], zero fill
    input  logic        s_tlast,   // last
    input  q_status_t   q_stat,
    output logic        push,
    output q_entry_t    entry
);

    logic [31:0] word;
    logic [2:0]  raw_cnt;
    logic [2:0]  cnt;
    logic [31:0] mask;

    assign word    = s_tdata[31:0];
    assign raw_cnt = s_tdata[34:32];

    always_comb begin
        if (!s_tlast || raw_cnt > FULL_BYTES) begin
            cnt = FULL_BYTES;
        end else begin
            cnt = raw_cnt;
        end
    end

    always_comb begin
        case (cnt)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    always_comb begin
        entry.word = word & mask;
        entry.cnt  = cnt;
        entry.last = s_tlast;
        if (cnt == FULL_BYTES) begin
            entry.kind = KIND_BLOCK;
        end else if (cnt == 3'd0) begin
            entry.kind = KIND_NONE;
        end else begin
            entry.kind = KIND_TAIL;
        end
    end

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

endmodule

// ===== hw/rtl/m3h_fifo.sv =====
// ----------------------------------------------------------------------------
// m3h_fifo
// Short register queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module m3h_fifo
    import m3h_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        store_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = store_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = 6'(count_reg);

endmodule

// ===== hw/rtl/m3h_back.sv =====
// ----------------------------------------------------------------------------
// m3h_back
// Sequencer that takes classified beats from the queue, runs the mix and
// fold of each block or tail beat, and on the final beat the length fold
// and finalizer, one multiplier per step, into an output register.
module m3h_back
    import m3h_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [31:0]  seed,
    input  q_entry_t     head,
    input  q_status_t    q_stat,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // hash_value [31:0]
    output back_status_t stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX1 = 3'd1;
    localparam logic [2:0] ST_MIX2 = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_FIN1 = 3'd4;
    localparam logic [2:0] ST_FIN2 = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        mid_reg, mid_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] tot_reg, tot_next;
    beat_kind_t  kind_reg, kind_next;
    logic        last_reg, last_next;

    logic [31:0] k_rot;
    logic [31:0] h_mix;
    logic [31:0] h_rot;
    logic [31:0] f_pre;
    logic [31:0] f_mid;

    assign k_rot = {k_reg[16:0], k_reg[31:17]};
    assign h_mix = h_reg ^ k_reg;
    assign h_rot = {h_mix[18:0], h_mix[31:19]};
    assign f_pre = (h_reg ^ tot_reg) ^ ((h_reg ^ tot_reg) >> 16);
    assign f_mid = k_reg ^ (k_reg >> 13);

    always_comb begin
        state_next     = state_reg;
        mid_next       = mid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        tot_next       = tot_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop       = 1'b1;
                    h_next    = mid_reg ? h_reg : seed;
                    tot_next  = (mid_reg ? tot_reg : 32'd0) + {29'd0, head.cnt};
                    k_next    = head.word;
                    kind_next = head.kind;
                    last_next = head.last;
                    state_next = (head.kind == KIND_NONE) ? ST_FIN1 : ST_MIX1;
                end
            end
            ST_MIX1: begin
                k_next     = k_reg * MIX_C1;
                state_next = ST_MIX2;
            end
            ST_MIX2: begin
                k_next     = k_rot * MIX_C2;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                if (kind_reg == KIND_BLOCK) begin
                    h_next = (h_rot << 2) + h_rot + FOLD_ADD;
                end else begin
                    h_next = h_reg ^ k_reg;
                end
                if (last_reg) begin
                    state_next = ST_FIN1;
                end else begin
                    mid_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN1: begin
                k_next     = f_pre * FIN_M1;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                k_next     = f_mid * FIN_M2;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = k_reg ^ (k_reg >> 16);
                    mid_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        h_reg        <= h_next;
        k_reg        <= k_next;
        tot_reg      <= tot_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;
    assign stat.mid       = mid_reg;
    assign stat.finishing = (state_reg == ST_OUT);
    assign stat.pop       = pop;

endmodule

// ===== hw/rtl/murmur3_32_hash.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_hash
// MurmurHash3 x86 32-bit over a stream of little-endian message words.
// ----------------------------------------------------------------------------
// Each beat carries one 32-bit word; a beat without tlast is a full 4-byte
// block, and the tlast beat carries 0 to 4 valid bytes given by byte_count
// (values above four count as four). One hash word leaves on the result
// channel for every tlast beat. The seed written on the configuration channel
// is loaded at the start of each message. Beats enter a short queue and are
// worked off by a sequencer that has one multiplier per step: a block or
// tail beat runs the mix and fold steps, the final beat then runs the
// finalizer, and an empty final beat goes straight to the finalizer.
module murmur3_32_hash
    import m3h_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [31:0] cfg_wdata,   // seed [31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // data_word [31:0], byte_count [34:32], zero fill
    input  logic        s_tlast,     // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // hash_value [31:0]
);

    logic [31:0]  seed_reg;
    logic         push;
    logic         pop;
    q_entry_t     push_entry;
    q_entry_t     head;
    q_status_t    q_stat;
    back_status_t b_stat;

    assign cfg_wready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_wvalid) begin
            seed_reg <= cfg_wdata;
        end
    end

    m3h_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (push_entry)
    );

    m3h_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    m3h_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .seed     (seed_reg),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .stat     (b_stat)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= 6'(QUEUE_DEPTH))
        else $error("queue holds more beats than its depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.pop |-> !q_stat.empty)
        else $error("back took a beat from an empty queue");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(b_stat.finishing))
        else $error("result appeared without a finished message");

    a_no_pop_while_finishing: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.finishing |-> !b_stat.pop)
        else $error("beat taken while a message was being finalized");

endmodule
